@@ design/crckfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crckfp_pkg
// Shared types, constants and CRC-32C (reflected Castagnoli) update functions.
// ----------------------------------------------------------------------------
package crckfp_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY     = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  // item mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  typedef logic [CRC_W-1:0] crc_t;
  typedef crc_t [CRC_W-1:0] crc_cols_t;

  typedef struct packed {
    logic              mode;
    logic [CRC_W-1:0]  state_ident;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } item_t;

  function automatic crc_t crc_shift1(crc_t c);
    return c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

  // one key byte, low bit first
  function automatic crc_t absorb_byte(crc_t c, logic [BYTE_W-1:0] b);
    crc_t r;
    r = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      r = crc_shift1(r);
    end
    return r;
  endfunction

  // Response of a 32-bit shift to each single input bit. Evaluated at
  // elaboration only; the runtime word update is an XOR of these columns.
  function automatic crc_cols_t word_columns();
    crc_cols_t cols;
    crc_t      r;
    for (int i = 0; i < CRC_W; i++) begin
      r = crc_t'(1) << i;
      for (int k = 0; k < CRC_W; k++) begin
        r = crc_shift1(r);
      end
      cols[i] = r;
    end
    return cols;
  endfunction

  localparam crc_cols_t WORD_COLS = word_columns();

  // four bytes, LSB first, of (crc ^ word): linear, so XOR of columns
  function automatic crc_t absorb_word(crc_t x);
    crc_t r;
    r = '0;
    for (int i = 0; i < CRC_W; i++) begin
      if (x[i]) begin
        r = r ^ WORD_COLS[i];
      end
    end
    return r;
  endfunction

endpackage

@@ design/crckfp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crckfp interfaces
// Valid/ready channels for input items and fingerprint results.
// ----------------------------------------------------------------------------
interface crckfp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] state_ident;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, mode, state_ident, data_byte, last, input ready);
  modport sink   (input valid, mode, state_ident, data_byte, last, output ready);
endinterface

interface crckfp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fingerprint;

  modport source (output valid, fingerprint, input ready);
  modport sink   (input valid, fingerprint, output ready);
endinterface

@@ design/crckfp_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crckfp_in_reg
// Input register: captures one transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module crckfp_in_reg
  import crckfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  crckfp_in_if.sink item,
  input  logic  take,
  output logic  held_valid,
  output item_t held
);

  assign item.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.ready) begin
      held_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held.mode        <= item.mode;
      held.state_ident <= item.state_ident;
      held.data_byte   <= item.data_byte;
      held.last        <= item.last;
    end
  end

endmodule

@@ design/crckfp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crckfp_core
// Running CRC update and fingerprint output register.
// ----------------------------------------------------------------------------
module crckfp_core
  import crckfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  held_valid,
  input  item_t held,
  output logic  take,
  crckfp_out_if.source result
);

  crc_t running_crc;
  crc_t crc_next;
  crc_t fp;
  logic out_valid;

  always_comb begin
    if (held.mode == MODE_START) begin
      crc_next = absorb_word(CRC_ALL_ONES ^ held.state_ident);
    end else begin
      crc_next = absorb_byte(running_crc, held.data_byte);
    end
  end

  // items without a result never wait on the output side
  assign take = held_valid && (!held.last || !out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_ALL_ONES;
    end else if (take) begin
      running_crc <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && held.last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held.last) begin
      fp <= ~crc_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.fingerprint = fp;

endmodule

@@ design/crc32c_keyed_fingerprint.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_keyed_fingerprint
// Keyed CRC-32C fingerprint: state id prefix plus key bytes.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while input ready is high (see below). A
// start transaction presets the CRC and folds in the 32-bit state id; a data
// transaction folds in one key byte. A transaction flagged last is loaded into
// the input register when accepted, and its fingerprint is loaded into the
// result register when the core takes it from there; the core holds it while
// the previous fingerprint is still untaken. The next transaction is accepted
// while that result waits. Input ready drops only when a last-flagged
// transaction sits in the input register and the previous fingerprint has not
// yet been taken. The running CRC is kept across fingerprints and resets to
// all ones.
module crc32c_keyed_fingerprint
  import crckfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  crckfp_in_if.sink    item,
  crckfp_out_if.source result
);

  logic  held_valid;
  item_t held;
  logic  take;

  crckfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  crckfp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held       (held),
    .take       (take),
    .result     (result)
  );

endmodule
